/* design/rzp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzp_pkg
// Shared widths, codes and the queue entry type of the point plotter.
// ----------------------------------------------------------------------------
package rzp_pkg;

   localparam int CELL_W     = 13;
   localparam int COORD_W    = 16;
   localparam int GLYPH_W    = 8;
   localparam int DEPTH_W    = 24;
   localparam int REQ_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int BYTE_W     = 8;
   // widest cell address over the legal screen sizes (1024 x 1024)
   localparam int MAX_ADDR_W = 20;
   // rotated coordinate width, trig operand width and trig fraction bits
   localparam int ROT_W      = 24;
   localparam int TRIG_W     = 17;
   localparam int FRAC_BITS  = 14;

   localparam int DEFAULT_SCREEN_WIDTH  = 160;
   localparam int DEFAULT_SCREEN_HEIGHT = 44;

   localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 8'd32;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 24'hFFFFFF;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PLOT  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COS_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_Z = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIST  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 3'd7;

   localparam logic signed [COORD_W-1:0] TRIG_ONE   = 16'sd16384;
   localparam logic [BYTE_W-1:0]         DIST_RESET  = 8'd60;
   localparam logic [BYTE_W-1:0]         SCALE_RESET = 8'd40;

   // work classes handed from front to back
   typedef enum logic [1:0] {
      OP_PLOT,
      OP_READ,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [MAX_ADDR_W-1:0]   addr;
      logic [DEPTH_W-1:0]      depth;
      logic [GLYPH_W-1:0]      glyph;
   } entry_type;

endpackage

/* design/rzp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzp_if
// Valid/ready channels for plot, read and clear requests and their results.
// ----------------------------------------------------------------------------
interface rzp_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rzp_pkg::REQ_W-1:0]            req_type;
   logic signed [rzp_pkg::COORD_W-1:0]   point_x;
   logic signed [rzp_pkg::COORD_W-1:0]   point_y;
   logic signed [rzp_pkg::COORD_W-1:0]   point_z;
   logic [rzp_pkg::GLYPH_W-1:0]          glyph_in;
   logic [rzp_pkg::CELL_W-1:0]           cell_index;

   modport source (output valid, req_type, point_x, point_y, point_z, glyph_in,
                   cell_index, input ready);
   modport sink (input valid, req_type, point_x, point_y, point_z, glyph_in,
                 cell_index, output ready);
endinterface

interface rzp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rzp_pkg::GLYPH_W-1:0]   glyph_out;
   logic                          was_written;
   logic [rzp_pkg::CELL_W-1:0]    cell_out;

   modport source (output valid, glyph_out, was_written, cell_out, input ready);
   modport sink (input valid, glyph_out, was_written, cell_out, output ready);
endinterface

/* design/rzp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rzp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* design/rzp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzp_queue
// Two-entry item queue between the transform front and the buffer back.
// ----------------------------------------------------------------------------
module rzp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  rzp_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output rzp_pkg::entry_type pop_entry
);

   rzp_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop)      count_ff <= count_ff + 2'd1;
         else if (do_pop && !do_push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

/* design/rzp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzp_front
// Accepts requests, holds the registers, rotates and projects plot points
// and queues classified work for the buffer side.
// ----------------------------------------------------------------------------
module rzp_front #(
   parameter int SCREEN_WIDTH  = rzp_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = rzp_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   rzp_req_if.sink                           req_ch,
   input  logic                              csr_wr_en,
   input  logic [rzp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rzp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              clear_done,
   output logic                              push_valid,
   input  logic                              push_ready,
   output rzp_pkg::entry_type                push_entry
);

   localparam int CELLS    = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int ROT_W    = rzp_pkg::ROT_W;
   localparam int TRIG_W   = rzp_pkg::TRIG_W;
   localparam int DEPTH_W  = rzp_pkg::DEPTH_W;
   localparam int PROD_W   = ROT_W + TRIG_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int ZQ_W     = ROT_W + 1;
   localparam int REM_W    = ZQ_W + 1;
   localparam int CNT_W    = $clog2(DEPTH_W + 1);
   // 2*K*x fits in 32 signed bits for every rotated coordinate
   localparam int K_W      = 32;
   localparam int PIX_W    = 64;
   localparam int SCR_W    = 32;
   // 2^32 / 2^DEPTH_W: the dividend bits above the quotient
   localparam logic [REM_W-1:0] DIV_SEED = REM_W'(1 << (32 - DEPTH_W));
   localparam logic signed [PIX_W-1:0] HALF_W_Q = PIX_W'(SCREEN_WIDTH / 2) << 32;
   localparam logic signed [PIX_W-1:0] HALF_H_Q = PIX_W'(SCREEN_HEIGHT / 2) << 32;

   typedef enum logic [3:0] {
      S_IDLE, S_ROT_X, S_ROT_Y, S_ROT_Z, S_DEPTH, S_DIV,
      S_SCALE, S_PROJ, S_PLACE, S_INDEX, S_PUSH
   } state_type;

   // registers
   logic signed [rzp_pkg::COORD_W-1:0] cos_x_ff, sin_x_ff, cos_y_ff, sin_y_ff;
   logic signed [rzp_pkg::COORD_W-1:0] cos_z_ff, sin_z_ff;
   logic [rzp_pkg::BYTE_W-1:0]         dist_ff, scale_ff;

   state_type                   state_ff;
   logic signed [ROT_W-1:0]     x_ff, y_ff, z_ff;
   logic signed [ZQ_W-1:0]      zq_ff;
   logic [REM_W-1:0]            rem_ff;
   logic [DEPTH_W-1:0]          quo_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic signed [K_W-1:0]       kx_ff, ky_ff;
   logic signed [PIX_W-1:0]     px_ff, py_ff;
   logic signed [SCR_W-1:0]     sx_ff, sy_ff;
   logic [rzp_pkg::GLYPH_W-1:0] glyph_ff;
   rzp_pkg::entry_type          entry_ff;

   // rotation datapath
   logic signed [TRIG_W-1:0] c_sel, s_sel;
   logic signed [PROD_W-1:0] pc, qs, ps, qc;
   logic signed [SUM_W-1:0]  u_sum, v_sum;
   logic signed [ROT_W-1:0]  u_rot, v_rot;
   // divider step
   logic [REM_W-1:0]         rem_sh;
   logic [REM_W-1:0]         divisor;
   logic                     take;
   // projection
   logic signed [PIX_W-1:0]  sum_x, sum_y;
   logic signed [SCR_W-1:0]  fl_x, fl_y, tr_x, tr_y;
   logic                     in_bounds;
   logic [ADDR_W-1:0]        plot_addr;
   logic                     cell_ok;
   logic                     accept;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && clear_done;
   assign push_valid   = (state_ff == S_PUSH);
   assign push_entry   = entry_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_x_ff <= rzp_pkg::TRIG_ONE;
         sin_x_ff <= '0;
         cos_y_ff <= rzp_pkg::TRIG_ONE;
         sin_y_ff <= '0;
         cos_z_ff <= rzp_pkg::TRIG_ONE;
         sin_z_ff <= '0;
         dist_ff  <= rzp_pkg::DIST_RESET;
         scale_ff <= rzp_pkg::SCALE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            rzp_pkg::CSR_COS_X: cos_x_ff <= csr_wdata;
            rzp_pkg::CSR_SIN_X: sin_x_ff <= csr_wdata;
            rzp_pkg::CSR_COS_Y: cos_y_ff <= csr_wdata;
            rzp_pkg::CSR_SIN_Y: sin_y_ff <= csr_wdata;
            rzp_pkg::CSR_COS_Z: cos_z_ff <= csr_wdata;
            rzp_pkg::CSR_SIN_Z: sin_z_ff <= csr_wdata;
            rzp_pkg::CSR_DIST:  dist_ff  <= csr_wdata[rzp_pkg::BYTE_W-1:0];
            rzp_pkg::CSR_SCALE: scale_ff <= csr_wdata[rzp_pkg::BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // rotation pair: u = p*c - q*s, v = p*s + q*c; Y uses the negated sine
   always_comb begin
      c_sel = TRIG_W'(cos_x_ff);
      s_sel = TRIG_W'(sin_x_ff);
      case (state_ff)
         S_ROT_Y: begin
            c_sel = TRIG_W'(cos_y_ff);
            s_sel = -TRIG_W'(sin_y_ff);
         end
         S_ROT_Z: begin
            c_sel = TRIG_W'(cos_z_ff);
            s_sel = TRIG_W'(sin_z_ff);
         end
         default: ;
      endcase
   end

   // operands: X pass uses (y, z), Y and Z passes use (x, z) and (x, y)
   logic signed [ROT_W-1:0] p_op, q_op;
   always_comb begin
      case (state_ff)
         S_ROT_X: begin p_op = y_ff; q_op = z_ff; end
         S_ROT_Y: begin p_op = x_ff; q_op = z_ff; end
         default: begin p_op = x_ff; q_op = y_ff; end
      endcase
   end

   assign pc    = p_op * c_sel;
   assign qs    = q_op * s_sel;
   assign ps    = p_op * s_sel;
   assign qc    = q_op * c_sel;
   assign u_sum = SUM_W'(pc) - SUM_W'(qs);
   assign v_sum = SUM_W'(ps) + SUM_W'(qc);
   // floor shift
   assign u_rot = ROT_W'(u_sum >>> rzp_pkg::FRAC_BITS);
   assign v_rot = ROT_W'(v_sum >>> rzp_pkg::FRAC_BITS);

   // restoring divide step for 2^32 / zq
   assign divisor = REM_W'(unsigned'(zq_ff));
   assign rem_sh  = rem_ff << 1;
   assign take    = (rem_sh >= divisor);

   // screen position, truncated toward zero
   assign sum_x = HALF_W_Q + px_ff;
   assign sum_y = HALF_H_Q + py_ff;
   assign fl_x  = SCR_W'(sum_x >>> 32);
   assign fl_y  = SCR_W'(sum_y >>> 32);
   assign tr_x  = fl_x + SCR_W'(sum_x[PIX_W-1] && (sum_x[31:0] != '0));
   assign tr_y  = fl_y + SCR_W'(sum_y[PIX_W-1] && (sum_y[31:0] != '0));

   assign in_bounds = (sx_ff >= 0) && (sx_ff < SCR_W'(SCREEN_WIDTH)) &&
                      (sy_ff >= 0) && (sy_ff < SCR_W'(SCREEN_HEIGHT));
   assign plot_addr = ADDR_W'(ADDR_W'(sx_ff) + ADDR_W'(sy_ff) * ADDR_W'(SCREEN_WIDTH));
   assign cell_ok   = (32'(req_ch.cell_index) < 32'(CELLS));

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  x_ff     <= ROT_W'(req_ch.point_x);
                  y_ff     <= ROT_W'(req_ch.point_y);
                  z_ff     <= ROT_W'(req_ch.point_z);
                  glyph_ff <= req_ch.glyph_in;
                  entry_ff.addr  <= rzp_pkg::MAX_ADDR_W'(req_ch.cell_index);
                  entry_ff.depth <= '0;
                  entry_ff.glyph <= req_ch.glyph_in;
                  if (req_ch.req_type == rzp_pkg::REQ_PLOT) begin
                     state_ff <= S_ROT_X;
                  end else begin
                     if (req_ch.req_type == rzp_pkg::REQ_READ && cell_ok)
                        entry_ff.op <= rzp_pkg::OP_READ;
                     else if (req_ch.req_type == rzp_pkg::REQ_CLEAR && cell_ok)
                        entry_ff.op <= rzp_pkg::OP_CLEAR;
                     else
                        entry_ff.op <= rzp_pkg::OP_NONE;
                     state_ff <= S_PUSH;
                  end
               end
            end
            S_ROT_X: begin
               y_ff     <= u_rot;
               z_ff     <= v_rot;
               state_ff <= S_ROT_Y;
            end
            S_ROT_Y: begin
               x_ff     <= u_rot;
               z_ff     <= v_rot;
               state_ff <= S_ROT_Z;
            end
            S_ROT_Z: begin
               x_ff     <= u_rot;
               y_ff     <= v_rot;
               zq_ff    <= ZQ_W'(z_ff) + ZQ_W'({dist_ff, 8'd0});
               state_ff <= S_DEPTH;
            end
            S_DEPTH: begin
               rem_ff <= DIV_SEED;
               cnt_ff <= '0;
               quo_ff <= rzp_pkg::DEPTH_MAX;
               if (zq_ff <= 0) begin
                  entry_ff.op <= rzp_pkg::OP_NONE;
                  state_ff    <= S_PUSH;
               end else if (zq_ff <= ZQ_W'(DIV_SEED)) begin
                  state_ff <= S_SCALE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               rem_ff <= take ? (rem_sh - divisor) : rem_sh;
               quo_ff <= {quo_ff[DEPTH_W-2:0], take};
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DEPTH_W - 1)) state_ff <= S_SCALE;
            end
            S_SCALE: begin
               kx_ff    <= (K_W'($signed({1'b0, scale_ff})) * K_W'(x_ff)) <<< 1;
               ky_ff    <= K_W'($signed({1'b0, scale_ff})) * K_W'(y_ff);
               state_ff <= S_PROJ;
            end
            S_PROJ: begin
               // 32 x 25 bit products, widened by the 64-bit destination
               px_ff    <= kx_ff * $signed({1'b0, quo_ff});
               py_ff    <= ky_ff * $signed({1'b0, quo_ff});
               state_ff <= S_PLACE;
            end
            S_PLACE: begin
               sx_ff    <= tr_x;
               sy_ff    <= tr_y;
               state_ff <= S_INDEX;
            end
            S_INDEX: begin
               entry_ff.op    <= in_bounds ? rzp_pkg::OP_PLOT : rzp_pkg::OP_NONE;
               entry_ff.addr  <= rzp_pkg::MAX_ADDR_W'(plot_addr);
               entry_ff.depth <= quo_ff;
               entry_ff.glyph <= glyph_ff;
               state_ff       <= S_PUSH;
            end
            S_PUSH: begin
               if (push_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* design/rzp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzp_back
// Clears the screen buffer after reset, then runs depth tests, reads and
// clears against it and holds each result until it is taken.
// ----------------------------------------------------------------------------
module rzp_back #(
   parameter int SCREEN_WIDTH  = rzp_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = rzp_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  rzp_pkg::entry_type pop_entry,
   output logic               clear_done,
   rzp_rsp_if.source          rsp_ch
);

   localparam int CELLS   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int DEPTH_W = rzp_pkg::DEPTH_W;
   localparam int GLYPH_W = rzp_pkg::GLYPH_W;
   localparam int WORD_W  = DEPTH_W + GLYPH_W;

   typedef enum logic [1:0] {
      B_CLEAR, B_IDLE, B_LOOK
   } state_type;

   state_type                 state_ff;
   logic [ADDR_W-1:0]         sweep_ff;
   rzp_pkg::entry_type        cur_ff;
   logic                      rsp_valid_ff;
   logic [GLYPH_W-1:0]        rsp_glyph_ff;
   logic                      rsp_written_ff;
   logic [rzp_pkg::CELL_W-1:0] rsp_cell_ff;

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr, rd_addr;
   logic [WORD_W-1:0]         wr_data, rd_data;
   logic [DEPTH_W-1:0]        old_depth;
   logic [GLYPH_W-1:0]        old_glyph;
   logic                      wins;

   assign clear_done = (state_ff != B_CLEAR);
   assign pop_ready  = (state_ff == B_IDLE) && !rsp_valid_ff;
   assign old_depth  = rd_data[WORD_W-1:GLYPH_W];
   assign old_glyph  = rd_data[GLYPH_W-1:0];
   assign wins       = (cur_ff.op == rzp_pkg::OP_PLOT) && (cur_ff.depth > old_depth);
   assign rd_addr    = ADDR_W'(pop_entry.addr);

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.glyph_out   = rsp_glyph_ff;
   assign rsp_ch.was_written = rsp_written_ff;
   assign rsp_ch.cell_out    = rsp_cell_ff;

   // buffer write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ADDR_W'(pop_entry.addr);
      wr_data = {{DEPTH_W{1'b0}}, rzp_pkg::BLANK_GLYPH};
      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_ff;
         end
         B_IDLE: begin
            wr_en = pop_valid && pop_ready && (pop_entry.op == rzp_pkg::OP_CLEAR);
         end
         B_LOOK: begin
            wr_en   = wins;
            wr_addr = ADDR_W'(cur_ff.addr);
            wr_data = {cur_ff.depth, cur_ff.glyph};
         end
         default: ;
      endcase
   end

   rzp_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            B_CLEAR: begin
               sweep_ff <= sweep_ff + ADDR_W'(1);
               if (sweep_ff == ADDR_W'(CELLS - 1)) state_ff <= B_IDLE;
            end
            B_IDLE: begin
               if (pop_valid && pop_ready) begin
                  cur_ff <= pop_entry;
                  case (pop_entry.op)
                     rzp_pkg::OP_PLOT, rzp_pkg::OP_READ: state_ff <= B_LOOK;
                     rzp_pkg::OP_CLEAR: begin
                        rsp_valid_ff   <= 1'b1;
                        rsp_glyph_ff   <= rzp_pkg::BLANK_GLYPH;
                        rsp_written_ff <= 1'b0;
                        rsp_cell_ff    <= rzp_pkg::CELL_W'(pop_entry.addr);
                     end
                     default: begin
                        rsp_valid_ff   <= 1'b1;
                        rsp_glyph_ff   <= '0;
                        rsp_written_ff <= 1'b0;
                        rsp_cell_ff    <= '0;
                     end
                  endcase
               end
            end
            B_LOOK: begin
               rsp_valid_ff   <= 1'b1;
               rsp_glyph_ff   <= wins ? cur_ff.glyph : old_glyph;
               rsp_written_ff <= wins;
               rsp_cell_ff    <= rzp_pkg::CELL_W'(cur_ff.addr);
               state_ff       <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

/* design/rotate_project_zbuffer_plot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_project_zbuffer_plot
// Rotating perspective point plotter over a depth-buffered character screen.
// ----------------------------------------------------------------------------
// Each request gives exactly one result, in request order. After reset the
// block sweeps the whole buffer, one cell per cycle, all SCREEN_WIDTH *
// SCREEN_HEIGHT cells (7040 by default), and takes no request until the sweep
// ends; register writes are taken throughout. Read and clear requests skip
// the transform and go straight to the queue. A plot holds the front from
// its acceptance until its entry is pushed, through the serial 2^32/z
// divider in the front (24 steps, one quotient bit a cycle; skipped when
// the inverse depth saturates); the buffer side reads, then writes the cell
// for its depth read-modify-write. A two-entry queue separates the two sides
// and a result register holds each result until the sink takes it.
// ----------------------------------------------------------------------------
module rotate_project_zbuffer_plot #(
   parameter int SCREEN_WIDTH  = rzp_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = rzp_pkg::DEFAULT_SCREEN_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   rzp_req_if.sink                        req_ch,
   rzp_rsp_if.source                      rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [rzp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rzp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic               push_valid, push_ready;
   logic               pop_valid, pop_ready;
   logic               clear_done;
   rzp_pkg::entry_type push_entry, pop_entry;

   rzp_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .clear_done (clear_done),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rzp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rzp_back #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .clear_done (clear_done),
      .rsp_ch     (rsp_ch)
   );

endmodule
